### src/tclq_pkg.sv
`timescale 1ns / 1ps

package tclq_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int EPOCH_W = 48;
    localparam int TILE_W  = 16;
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 24;
    localparam int CIDX_W  = 2;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // Item commands.
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_ORIGIN_X  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ORIGIN_Z  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_TILE_SIZE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch an accepted item
        logic record;   // write the ring and advance the epoch
        logic diff;     // form the epoch distance of a query
        logic setup;    // judge early answers and set up the scan
        logic issue;    // read one ring slot into the compare pipeline
        logic respond;  // result is on the ports this cycle
        logic cfg_we;   // configuration write
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query;
        logic early_done;
        logic last_issue;
        logic pipe_busy;
        logic hit;
    } ctl_stat_t;

endpackage

### src/tclq_ctrl.sv
`timescale 1ns / 1ps

module tclq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cfg_valid,
    input  tclq_pkg::ctl_stat_t  stat,
    output tclq_pkg::ctl_cmd_t   cmd,
    output logic                 busy,
    output logic                 done,
    output logic                 cfg_ready
);

    tclq_pkg::ctl_state_t state_reg;
    tclq_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tclq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tclq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tclq_pkg::ST_EXEC;
                end
            end
            tclq_pkg::ST_EXEC:
            begin
                state_next = stat.query ? tclq_pkg::ST_CHECK : tclq_pkg::ST_RESP;
            end
            tclq_pkg::ST_CHECK:
            begin
                state_next = stat.early_done ? tclq_pkg::ST_RESP : tclq_pkg::ST_SCAN;
            end
            tclq_pkg::ST_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = tclq_pkg::ST_RESP;
                end
                else if (stat.last_issue)
                begin
                    state_next = tclq_pkg::ST_DRAIN;
                end
            end
            tclq_pkg::ST_DRAIN:
            begin
                if (stat.hit || !stat.pipe_busy)
                begin
                    state_next = tclq_pkg::ST_RESP;
                end
            end
            tclq_pkg::ST_RESP:
            begin
                state_next = tclq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tclq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == tclq_pkg::ST_IDLE) && start;
        cmd.record  = (state_reg == tclq_pkg::ST_EXEC) && !stat.query;
        cmd.diff    = (state_reg == tclq_pkg::ST_EXEC) && stat.query;
        cmd.setup   = (state_reg == tclq_pkg::ST_CHECK);
        cmd.issue   = (state_reg == tclq_pkg::ST_SCAN) && !stat.hit;
        cmd.respond = (state_reg == tclq_pkg::ST_RESP);
        cmd.cfg_we  = (state_reg == tclq_pkg::ST_IDLE) && cfg_valid;
        busy        = (state_reg != tclq_pkg::ST_IDLE);
        done        = (state_reg == tclq_pkg::ST_RESP);
        cfg_ready   = (state_reg == tclq_pkg::ST_IDLE);
    end

    // A scan read is only issued from the scan state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> state_reg == tclq_pkg::ST_SCAN)
        else $error("ring read issued outside the scan");

    // Every result strobe ends the item and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("controller did not return to idle after a result");

    // A record never goes through the scan states.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.record |=> state_reg == tclq_pkg::ST_RESP)
        else $error("record did not respond directly");

endmodule

### src/tclq_datapath.sv
`timescale 1ns / 1ps

module tclq_datapath
#(
    parameter int RING_DEPTH = tclq_pkg::RING_DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tclq_pkg::ctl_cmd_t                   cmd,
    output tclq_pkg::ctl_stat_t                  stat,
    input  logic                                 command,
    input  logic signed [tclq_pkg::TILE_W-1:0]   tile_x,
    input  logic signed [tclq_pkg::TILE_W-1:0]   tile_y,
    input  logic        [tclq_pkg::EPOCH_W-1:0]  since_epoch,
    input  logic signed [tclq_pkg::COORD_W-1:0]  min_x,
    input  logic signed [tclq_pkg::COORD_W-1:0]  min_z,
    input  logic signed [tclq_pkg::COORD_W-1:0]  max_x,
    input  logic signed [tclq_pkg::COORD_W-1:0]  max_z,
    input  logic        [tclq_pkg::CIDX_W-1:0]   cfg_index,
    input  logic        [tclq_pkg::COORD_W-1:0]  cfg_data,
    output logic                                 changed,
    output logic        [tclq_pkg::EPOCH_W-1:0]  epoch_now
);

    localparam int IDXW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNTW  = $clog2(RING_DEPTH + 1);
    localparam int SW    = IDXW + 1;
    localparam int EW    = tclq_pkg::EPOCH_W;
    localparam int TW    = tclq_pkg::TILE_W;
    localparam int CW    = tclq_pkg::COORD_W;
    localparam int ZW    = tclq_pkg::SIZE_W;
    localparam int ENT_W = EW + 2 * TW;
    localparam int PW    = TW + ZW + 1;     // tile index times tile size
    localparam int BW    = PW + 2;          // tile bounds, with origin and size added

    localparam logic [IDXW-1:0] SLOT_LAST = IDXW'(RING_DEPTH - 1);
    localparam logic [SW-1:0]   DEPTH_S   = SW'(RING_DEPTH);

    // Configuration.
    logic signed [CW-1:0] org_x_reg;
    logic signed [CW-1:0] org_z_reg;
    logic        [ZW-1:0] tile_size_reg;

    // Epoch and the ring slot that it maps to.
    logic [EW-1:0]   epoch_reg;
    logic [IDXW-1:0] cur_slot_reg;

    // Latched item.
    logic                 command_reg;
    logic signed [TW-1:0] tile_x_reg;
    logic signed [TW-1:0] tile_y_reg;
    logic [EW-1:0]        since_reg;
    logic signed [CW-1:0] min_x_reg;
    logic signed [CW-1:0] min_z_reg;
    logic signed [CW-1:0] max_x_reg;
    logic signed [CW-1:0] max_z_reg;

    // Query setup and scan.
    logic [EW:0]     diff_reg;
    logic [IDXW-1:0] scan_slot_reg;
    logic [EW-1:0]   scan_epoch_reg;
    logic [CNTW-1:0] scan_left_reg;
    logic            answer_reg;

    // Compare pipeline.
    logic                 va_reg;
    logic                 vb_reg;
    logic                 vc_reg;
    logic [EW-1:0]        tag_a_reg;
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 mismatch_b_reg;
    logic                 mismatch_c_reg;
    logic signed [PW-1:0] px_b_reg;
    logic signed [PW-1:0] pz_b_reg;
    logic signed [BW-1:0] tminx_c_reg;
    logic signed [BW-1:0] tminz_c_reg;

    logic [ENT_W-1:0] ring_mem [RING_DEPTH];

    // Combinational terms.
    logic                 sat;
    logic [EW-1:0]        rec_epoch;
    logic [IDXW-1:0]      rec_slot;
    logic                 early_zero;
    logic                 early_one;
    logic [SW-1:0]        slot_sum;
    logic [IDXW-1:0]      slot_init;
    logic [EW-1:0]        rd_epoch;
    logic signed [TW-1:0] rd_x;
    logic signed [TW-1:0] rd_y;
    logic signed [ZW:0]   tile_s;
    logic signed [BW-1:0] tmaxx;
    logic signed [BW-1:0] tmaxz;
    logic                 ov_x;
    logic                 ov_z;
    logic                 hit_c;

    always_comb
    begin
        sat       = (epoch_reg == tclq_pkg::EPOCH_MAX);
        rec_epoch = sat ? epoch_reg : epoch_reg + EW'(1);
        if (sat)
        begin
            rec_slot = cur_slot_reg;
        end
        else
        begin
            rec_slot = (cur_slot_reg == SLOT_LAST) ? '0 : cur_slot_reg + IDXW'(1);
        end

        early_zero = diff_reg[EW] || (diff_reg[EW-1:0] == '0);
        early_one  = !early_zero
                     && ((diff_reg[EW-1:0] > EW'(RING_DEPTH)) || (tile_size_reg == '0));

        // Slot of the oldest epoch to check; fits below twice the depth.
        slot_sum  = SW'(cur_slot_reg) + DEPTH_S + SW'(1) - SW'(diff_reg[CNTW-1:0]);
        slot_init = (slot_sum >= DEPTH_S) ? IDXW'(slot_sum - DEPTH_S) : IDXW'(slot_sum);

        rd_epoch = rd_data_reg[ENT_W-1 -: EW];
        rd_x     = rd_data_reg[2*TW-1 -: TW];
        rd_y     = rd_data_reg[TW-1:0];

        tile_s = $signed({1'b0, tile_size_reg});
        tmaxx  = tminx_c_reg + BW'(tile_s);
        tmaxz  = tminz_c_reg + BW'(tile_s);
        ov_x   = (BW'(max_x_reg) >= tminx_c_reg) && (BW'(min_x_reg) <= tmaxx);
        ov_z   = (BW'(max_z_reg) >= tminz_c_reg) && (BW'(min_z_reg) <= tmaxz);
        hit_c  = vc_reg && (mismatch_c_reg || (ov_x && ov_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg      <= '0;
            org_z_reg      <= '0;
            tile_size_reg  <= '0;
            epoch_reg      <= '0;
            cur_slot_reg   <= '0;
            scan_slot_reg  <= '0;
            scan_left_reg  <= '0;
            answer_reg     <= 1'b0;
            va_reg         <= 1'b0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                unique case (cfg_index)
                    tclq_pkg::CFG_ORIGIN_X:  org_x_reg     <= $signed(cfg_data);
                    tclq_pkg::CFG_ORIGIN_Z:  org_z_reg     <= $signed(cfg_data);
                    tclq_pkg::CFG_TILE_SIZE: tile_size_reg <= cfg_data[ZW-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.record)
            begin
                epoch_reg    <= rec_epoch;
                cur_slot_reg <= rec_slot;
            end

            if (cmd.setup)
            begin
                scan_slot_reg <= slot_init;
                scan_left_reg <= diff_reg[CNTW-1:0];
            end
            else if (cmd.issue)
            begin
                scan_slot_reg <= (scan_slot_reg == SLOT_LAST) ? '0
                                 : scan_slot_reg + IDXW'(1);
                scan_left_reg <= scan_left_reg - CNTW'(1);
            end

            if (cmd.load)
            begin
                answer_reg <= 1'b0;
            end
            else if (cmd.setup)
            begin
                answer_reg <= early_one;
            end
            else if (hit_c)
            begin
                answer_reg <= 1'b1;
            end

            if (cmd.load)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
            end
            else
            begin
                va_reg <= cmd.issue;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
            end
        end
    end

    // Item latch and pipeline payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= command;
            tile_x_reg  <= tile_x;
            tile_y_reg  <= tile_y;
            since_reg   <= since_epoch;
            min_x_reg   <= min_x;
            min_z_reg   <= min_z;
            max_x_reg   <= max_x;
            max_z_reg   <= max_z;
        end
        if (cmd.diff)
        begin
            diff_reg <= {1'b0, epoch_reg} - {1'b0, since_reg};
        end
        if (cmd.setup)
        begin
            scan_epoch_reg <= since_reg + EW'(1);
        end
        else if (cmd.issue)
        begin
            scan_epoch_reg <= scan_epoch_reg + EW'(1);
        end
        if (cmd.issue)
        begin
            tag_a_reg <= scan_epoch_reg;
        end
        mismatch_b_reg <= (rd_epoch != tag_a_reg);
        px_b_reg       <= PW'(rd_x * tile_s);
        pz_b_reg       <= PW'(rd_y * tile_s);
        mismatch_c_reg <= mismatch_b_reg;
        tminx_c_reg    <= BW'(org_x_reg) + BW'(px_b_reg);
        tminz_c_reg    <= BW'(org_z_reg) + BW'(pz_b_reg);
    end

    // Ring memory: one write port for records, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            ring_mem[rec_slot] <= {rec_epoch, tile_x_reg, tile_y_reg};
        end
        if (cmd.issue)
        begin
            rd_data_reg <= ring_mem[scan_slot_reg];
        end
    end

    always_comb
    begin
        stat.query      = (command_reg == tclq_pkg::CMD_QUERY);
        stat.early_done = early_zero || early_one;
        stat.last_issue = (scan_left_reg == CNTW'(1));
        stat.pipe_busy  = va_reg || vb_reg || vc_reg;
        stat.hit        = answer_reg;
        changed         = answer_reg;
        epoch_now       = epoch_reg;
    end

    // The epoch never moves backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> epoch_reg >= $past(epoch_reg))
        else $error("epoch decreased");

    // A scan read always has a slot left to visit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> scan_left_reg != '0)
        else $error("ring read beyond the requested epochs");

    // A record item never reports a change.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond && (command_reg == tclq_pkg::CMD_RECORD) |-> !answer_reg)
        else $error("record reported a change");

    // Once found, a change stays reported until the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        answer_reg && !cmd.load && !cmd.setup |=> answer_reg)
        else $error("change answer dropped during a query");

endmodule

### src/tile_change_log_overlap_query.sv
`timescale 1ns / 1ps

// Tile change log with box overlap query.
// Items enter on the command channel: an item is taken when start is high and
// busy is low, with command selecting a record (0) or a query (1). A record
// advances the epoch (saturating at its maximum) and logs the tile in the ring.
// A query reports whether anything logged after since_epoch may touch the box.
// Each item produces one result transaction: done is high for exactly one cycle
// with changed and epoch_now valid. The receiver cannot stall, so results are
// never held back.
// A record is latched, written to the ring in exec and answered in resp. A
// query settled by its epoch distance or a zero tile size is answered after
// check; otherwise the ring is scanned one slot per cycle through a single
// read port and a three-stage compare pipeline over the N logged epochs (at
// most RING_DEPTH), stopping early on the first overlap or epoch tag mismatch
// found. busy drops in the cycle after done, so the next item can be taken
// there; items are not overlapped.
// Configuration writes (origin_x, origin_z, tile_size) go through the cfg
// channel and are accepted while the block is idle.
// Reset clears the epoch, the configuration and all control state. The ring
// contents are left as they are and are only read at epochs already logged.
module tile_change_log_overlap_query
#(
    parameter int RING_DEPTH = tclq_pkg::RING_DEPTH_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic signed [tclq_pkg::TILE_W-1:0]   tile_x,
    input  logic signed [tclq_pkg::TILE_W-1:0]   tile_y,
    input  logic        [tclq_pkg::EPOCH_W-1:0]  since_epoch,
    input  logic signed [tclq_pkg::COORD_W-1:0]  min_x,
    input  logic signed [tclq_pkg::COORD_W-1:0]  min_z,
    input  logic signed [tclq_pkg::COORD_W-1:0]  max_x,
    input  logic signed [tclq_pkg::COORD_W-1:0]  max_z,
    output logic                                 done,
    output logic                                 changed,
    output logic        [tclq_pkg::EPOCH_W-1:0]  epoch_now,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [tclq_pkg::CIDX_W-1:0]   cfg_index,
    input  logic        [tclq_pkg::COORD_W-1:0]  cfg_data
);

    // The controller sequences each item; the datapath holds the log and does
    // all arithmetic.
    tclq_pkg::ctl_cmd_t  cmd;
    tclq_pkg::ctl_stat_t stat;

    tclq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready)
    );

    tclq_datapath
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (command),
        .tile_x      (tile_x),
        .tile_y      (tile_y),
        .since_epoch (since_epoch),
        .min_x       (min_x),
        .min_z       (min_z),
        .max_x       (max_x),
        .max_z       (max_z),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .changed     (changed),
        .epoch_now   (epoch_now)
    );

endmodule
